@@ sv/apn_pkg.sv @@
// apn_pkg: shared types and constants for the audio peak normalizer.
// Used by apn_div, audio_peak_normalizer_top and the sim checker and testbench; depends on nothing.
package apn_pkg;

    localparam int STORE_DEPTH = 4096;
    localparam int SAMPLE_BITS = 24;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int CNT_W       = ADDR_W + 1;
    localparam int SCALE_W     = 32;
    localparam int FRAC_SHIFT  = 17;
    localparam int NUM_W       = SAMPLE_BITS + FRAC_SHIFT + 1;
    localparam int PROD_W      = SAMPLE_BITS + SCALE_W;
    localparam int CFG_IDX_W   = 1;

    localparam logic [SAMPLE_BITS-1:0] SAMPLE_SIGN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    localparam logic [SAMPLE_BITS-1:0] SAMPLE_MAX  = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic [SAMPLE_BITS-1:0] PEAK_FLOOR  =
        SAMPLE_BITS'((64'd1 << (SAMPLE_BITS - 1)) / 64'd1000000);
    localparam logic [SCALE_W-1:0]     UNITY       = SCALE_W'(65536);
    localparam logic [SAMPLE_BITS-1:0] TARGET_RST  = SAMPLE_BITS'(4194304);

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MODE   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET = 1'b1;

    typedef enum logic [1:0] {
        MODE_NONE,
        MODE_RAISE,
        MODE_LOWER,
        MODE_ALWAYS
    } t_mode;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_MUL,
        ST_RND
    } t_state;

    typedef struct packed {
        logic                          kind;
        logic signed [SAMPLE_BITS-1:0] sample_in;
        logic                          last_in;
    } t_in_word;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample_out;
        logic                          last_out;
        logic                          clip_overflow;
    } t_out_word;

endpackage

@@ sv/apn_div.sv @@
// apn_div: restoring divider, one quotient bit per cycle, saturating output.
// Depends on apn_pkg.
module apn_div import apn_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    input  logic [NUM_W-1:0]       i_num,
    input  logic [SAMPLE_BITS-1:0] i_den,
    output logic                   o_done,
    output logic [SCALE_W-1:0]     o_quot
);

    localparam int STEP_W = $clog2(NUM_W + 1);

    logic                   r_run;
    logic                   r_done;
    logic [STEP_W-1:0]      r_cnt;
    logic [NUM_W-1:0]       r_num;
    logic [SAMPLE_BITS-1:0] r_den;
    logic [SAMPLE_BITS-1:0] r_rem;

    logic [SAMPLE_BITS:0]   w_rem_sh;
    logic                   w_ge;
    logic [SAMPLE_BITS:0]   w_rem_sub;

    always_comb begin
        w_rem_sh  = {r_rem, r_num[NUM_W-1]};
        w_ge      = (w_rem_sh >= {1'b0, r_den});
        w_rem_sub = w_rem_sh - {1'b0, r_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_run <= 1'b1;
                r_cnt <= '0;
            end else if (r_run) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == STEP_W'(NUM_W - 1)) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath: quotient bits shift in where numerator bits shift out
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_num;
            r_den <= i_den;
            r_rem <= '0;
        end else if (r_run) begin
            r_num <= {r_num[NUM_W-2:0], w_ge};
            r_rem <= w_ge ? w_rem_sub[SAMPLE_BITS-1:0] : w_rem_sh[SAMPLE_BITS-1:0];
        end
    end

    assign o_done = r_done;
    assign o_quot = (|r_num[NUM_W-1:SCALE_W]) ? {SCALE_W{1'b1}} : r_num[SCALE_W-1:0];

endmodule

@@ sv/audio_peak_normalizer_top.sv @@
// audio_peak_normalizer_top: clip store, peak tracking and gain application.
// Depends on apn_pkg and apn_div.
//
// Load words: one per cycle, busy stays low; a load marked last that needs a
// gain holds busy while apn_div computes it.
// Drain words: one at a time (store read, multiply, round); o_strobe rises
// with the rounded word as busy drops, and the word is taken while it is high.
// Results cannot be stalled.
// Reset (sync, active low) clears control state and config registers but not
// the drain datapath or the sample store; entries are read only after being written.
module audio_peak_normalizer_top import apn_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // command channel
    input  logic                   start,
    output logic                   busy,
    input  t_in_word               i_item,
    // result channel
    output logic                   o_strobe,
    output t_out_word              o_result,
    // configuration write port
    input  logic                   i_cfg_we,
    input  logic [CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [SAMPLE_BITS-1:0] i_cfg_data
);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    t_mode                  r_mode;
    logic [SAMPLE_BITS-1:0] r_target;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= MODE_NONE;
            r_target <= TARGET_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_MODE:   r_mode   <= t_mode'(i_cfg_data[1:0]);
                CFG_TARGET: r_target <= i_cfg_data;
                default:    ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Control state
    // ------------------------------------------------------------------
    t_state                 r_state,  n_state;
    logic [CNT_W-1:0]       r_count,  n_count;
    logic [CNT_W-1:0]       r_rd_idx, n_rd_idx;
    logic [SAMPLE_BITS-1:0] r_peak,   n_peak;
    logic [SCALE_W-1:0]     r_scale,  n_scale;
    logic                   r_closed, n_closed;
    logic                   r_ovf,    n_ovf;
    logic                   r_strobe, n_strobe;

    // store access
    logic                   w_mem_we;
    logic [ADDR_W-1:0]      w_mem_wa;
    logic                   w_mem_re;
    logic [SAMPLE_BITS-1:0] w_in_mag;

    // base values: a load after a closed clip starts a new one
    logic [CNT_W-1:0]       w_cnt_b;
    logic [SAMPLE_BITS-1:0] w_peak_b;
    logic                   w_ovf_b;
    logic                   w_apply;

    // divider hookup
    logic                   w_div_start;
    logic [NUM_W-1:0]       w_div_num;
    logic                   w_div_done;
    logic [SCALE_W-1:0]     w_div_quot;

    logic                   w_accept;

    assign busy     = (r_state != ST_IDLE);
    assign w_accept = start && !busy;

    always_comb begin
        w_in_mag = i_item.sample_in[SAMPLE_BITS-1] ?
                   (~i_item.sample_in + 1'b1) : i_item.sample_in;
    end

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_rd_idx    = r_rd_idx;
        n_peak      = r_peak;
        n_scale     = r_scale;
        n_closed    = r_closed;
        n_ovf       = r_ovf;
        n_strobe    = 1'b0;
        w_mem_we    = 1'b0;
        w_mem_re    = 1'b0;
        w_div_start = 1'b0;
        w_apply     = 1'b0;
        w_cnt_b     = r_closed ? '0 : r_count;
        w_peak_b    = r_closed ? '0 : r_peak;
        w_ovf_b     = r_closed ? 1'b0 : r_ovf;
        w_mem_wa    = w_cnt_b[ADDR_W-1:0];

        unique case (r_state)
            ST_IDLE: begin
                if (w_accept && !i_item.kind) begin
                    // load word
                    n_count  = w_cnt_b;
                    n_peak   = w_peak_b;
                    n_ovf    = w_ovf_b;
                    if (r_closed) begin
                        n_rd_idx = '0;
                        n_closed = 1'b0;
                        n_scale  = UNITY;
                    end
                    if (w_cnt_b < CNT_W'(STORE_DEPTH)) begin
                        w_mem_we = 1'b1;
                        n_count  = w_cnt_b + 1'b1;
                        if (w_in_mag > w_peak_b) begin
                            n_peak = w_in_mag;
                        end
                    end else begin
                        n_ovf = 1'b1;   // store full, sample dropped
                    end
                    if (i_item.last_in) begin
                        n_closed = 1'b1;
                        n_scale  = UNITY;
                        if (n_peak >= PEAK_FLOOR) begin
                            unique case (r_mode)
                                MODE_RAISE:  w_apply = ({1'b0, n_peak} < {r_target, 1'b0});
                                MODE_LOWER:  w_apply = ({1'b0, n_peak} > {r_target, 1'b0});
                                MODE_ALWAYS: w_apply = 1'b1;
                                default:     w_apply = 1'b0;
                            endcase
                        end
                        if (w_apply) begin
                            w_div_start = 1'b1;
                            n_state     = ST_DIV;
                        end
                    end
                end else if (w_accept && i_item.kind) begin
                    // drain word: silent unless closed and not past the end
                    if (r_closed && (r_rd_idx < r_count)) begin
                        w_mem_re = 1'b1;
                        n_rd_idx = r_rd_idx + 1'b1;
                        n_state  = ST_MUL;
                    end
                end
            end
            ST_DIV: begin
                if (w_div_done) begin
                    n_scale = w_div_quot;
                    n_state = ST_IDLE;
                end
            end
            ST_MUL: begin
                n_state = ST_RND;
            end
            ST_RND: begin
                n_strobe = 1'b1;
                n_state  = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_count  <= '0;
            r_rd_idx <= '0;
            r_peak   <= '0;
            r_scale  <= UNITY;
            r_closed <= 1'b0;
            r_ovf    <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_rd_idx <= n_rd_idx;
            r_peak   <= n_peak;
            r_scale  <= n_scale;
            r_closed <= n_closed;
            r_ovf    <= n_ovf;
            r_strobe <= n_strobe;
        end
    end

    // ------------------------------------------------------------------
    // Gain divider: scale = round(target * 2^17 / peak)
    // ------------------------------------------------------------------
    assign w_div_num = {1'b0, r_target, {FRAC_SHIFT{1'b0}}} + NUM_W'(n_peak >> 1);

    apn_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_div_num),
        .i_den   (n_peak),
        .o_done  (w_div_done),
        .o_quot  (w_div_quot)
    );

    // ------------------------------------------------------------------
    // Sample store: one write or one read per cycle, registered read
    // ------------------------------------------------------------------
    logic [SAMPLE_BITS-1:0] r_mem [STORE_DEPTH];
    logic [SAMPLE_BITS-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_mem[w_mem_wa] <= i_item.sample_in;
        end
        if (w_mem_re) begin
            r_rd_data <= r_mem[r_rd_idx[ADDR_W-1:0]];
        end
    end

    // ------------------------------------------------------------------
    // Drain datapath: magnitude * scale, then round half away and clamp
    // ------------------------------------------------------------------
    logic                   r_last_rd;
    logic                   r_neg;
    logic                   r_last_p;
    logic [PROD_W-1:0]      r_prod;
    t_out_word              r_out;

    logic [SAMPLE_BITS-1:0] w_rd_mag;
    logic [PROD_W-1:0]      w_prod_rnd;
    logic [PROD_W-17:0]     w_res;
    logic [SAMPLE_BITS-1:0] w_res_sat;

    always_comb begin
        w_rd_mag   = r_rd_data[SAMPLE_BITS-1] ? (~r_rd_data + 1'b1) : r_rd_data;
        w_prod_rnd = r_prod + PROD_W'(32768);
        w_res      = w_prod_rnd[PROD_W-1:16];
        if (r_neg) begin
            w_res_sat = (w_res > (PROD_W-16)'(SAMPLE_SIGN)) ?
                        SAMPLE_SIGN : w_res[SAMPLE_BITS-1:0];
            w_res_sat = ~w_res_sat + 1'b1;
        end else begin
            w_res_sat = (w_res > (PROD_W-16)'(SAMPLE_MAX)) ?
                        SAMPLE_MAX : w_res[SAMPLE_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_mem_re) begin
            r_last_rd <= ((r_rd_idx + 1'b1) == r_count);
        end
        if (r_state == ST_MUL) begin
            r_prod   <= PROD_W'(w_rd_mag) * PROD_W'(r_scale);
            r_neg    <= r_rd_data[SAMPLE_BITS-1];
            r_last_p <= r_last_rd;
        end
        if (r_state == ST_RND) begin
            r_out.sample_out    <= w_res_sat;
            r_out.last_out      <= r_last_p;
            r_out.clip_overflow <= r_ovf;
        end
    end

    assign o_strobe = r_strobe;
    assign o_result = r_out;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_strobe_after_round: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(r_state == ST_RND))
        else $error("result strobe without a rounding cycle");

    a_div_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> (r_state == ST_DIV))
        else $error("divider finished outside the divide state");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(STORE_DEPTH))
        else $error("stored count beyond store depth");

    a_index_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rd_idx <= r_count)
        else $error("read index passed stored count");

    a_drain_needs_close: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_MUL) |-> r_closed)
        else $error("store read while clip open");

endmodule

@@ sim/apn_gain_checker.sv @@
`timescale 1ns / 100ps
// apn_gain_checker: mirrors clip store, peak and gain of the normalizer from
// its command, config and result ports and checks every result word. Uses apn_pkg.
module apn_gain_checker import apn_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    input  logic                   i_busy,
    input  t_in_word               i_item,
    input  logic                   i_strobe,
    input  t_out_word              i_result,
    input  logic                   i_cfg_we,
    input  logic [CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [SAMPLE_BITS-1:0] i_cfg_data,
    output int                     o_fail_count,
    output int                     o_words_due
);

    // mirrored block state
    logic [SAMPLE_BITS-1:0] clip_mem [STORE_DEPTH];
    int unsigned            n_stored;
    int unsigned            rd_ptr;
    logic [SAMPLE_BITS-1:0] peak;
    logic [SCALE_W-1:0]     gain;
    bit                     closed;
    bit                     dropped;
    t_mode                  mode;
    logic [SAMPLE_BITS-1:0] target;

    t_out_word scaled_words_due [$];
    t_out_word want;
    int        n_fail;
    logic [SAMPLE_BITS-1:0] mag;

    function automatic logic [SAMPLE_BITS-1:0] magnitude(input logic [SAMPLE_BITS-1:0] s);
        return s[SAMPLE_BITS-1] ? SAMPLE_BITS'(-s) : s;
    endfunction

    function automatic void open_clip();
        n_stored = 0;
        rd_ptr   = 0;
        peak     = '0;
        gain     = UNITY;
        closed   = 1'b0;
        dropped  = 1'b0;
    endfunction

    // gain = round(target * 2^17 / peak), clamped to 32 bits
    function automatic void close_clip();
        logic [63:0]          quo;
        logic [SAMPLE_BITS:0] tgt2;
        bit                   apply;
        closed = 1'b1;
        gain   = UNITY;
        if (peak == '0 || peak < PEAK_FLOOR)
            return;
        tgt2 = {target, 1'b0};
        case (mode)
            MODE_RAISE:  apply = {1'b0, peak} < tgt2;
            MODE_LOWER:  apply = {1'b0, peak} > tgt2;
            MODE_ALWAYS: apply = 1'b1;
            default:     apply = 1'b0;
        endcase
        if (apply) begin
            quo  = ((64'(target) << FRAC_SHIFT) + 64'(peak >> 1)) / 64'(peak);
            gain = (quo > 64'hFFFF_FFFF) ? '1 : quo[SCALE_W-1:0];
        end
    endfunction

    function automatic t_out_word scaled_word();
        logic [SAMPLE_BITS-1:0] s;
        logic [63:0]            res;
        t_out_word              w;
        s   = clip_mem[rd_ptr];
        res = (64'(magnitude(s)) * 64'(gain) + 64'd32768) >> 16;
        if (s[SAMPLE_BITS-1]) begin
            if (res > 64'(SAMPLE_SIGN))
                res = 64'(SAMPLE_SIGN);
            w.sample_out = -res[SAMPLE_BITS-1:0];
        end else begin
            if (res > 64'(SAMPLE_MAX))
                res = 64'(SAMPLE_MAX);
            w.sample_out = res[SAMPLE_BITS-1:0];
        end
        w.last_out      = (rd_ptr + 1 == n_stored);
        w.clip_overflow = dropped;
        return w;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            open_clip();
            mode   = MODE_NONE;
            target = TARGET_RST;
            n_fail = 0;
            scaled_words_due.delete();
        end else begin
            if (i_strobe) begin
                if (scaled_words_due.size() == 0) begin
                    n_fail++;
                    $display("%0t: unexpected word: expected none, got %h/%b/%b",
                             $time, i_result.sample_out, i_result.last_out,
                             i_result.clip_overflow);
                end else begin
                    want = scaled_words_due.pop_front();
                    if (i_result.sample_out !== want.sample_out ||
                        i_result.last_out !== want.last_out ||
                        i_result.clip_overflow !== want.clip_overflow) begin
                        n_fail++;
                        $display("%0t: word mismatch: expected %h/%b/%b, got %h/%b/%b",
                                 $time, want.sample_out, want.last_out,
                                 want.clip_overflow, i_result.sample_out,
                                 i_result.last_out, i_result.clip_overflow);
                    end
                end
            end

            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_MODE)
                    mode = t_mode'(i_cfg_data[1:0]);
                else if (i_cfg_idx == CFG_TARGET)
                    target = i_cfg_data;
            end

            if (i_start && !i_busy) begin
                if (i_item.kind) begin
                    // drain: only inside a closed clip, never past its end
                    if (closed && rd_ptr < n_stored) begin
                        scaled_words_due.push_back(scaled_word());
                        rd_ptr++;
                    end
                end else begin
                    if (closed)
                        open_clip();
                    if (n_stored < STORE_DEPTH) begin
                        clip_mem[n_stored] = i_item.sample_in;
                        n_stored++;
                        mag = magnitude(i_item.sample_in);
                        if (mag > peak)
                            peak = mag;
                    end else begin
                        dropped = 1'b1;
                    end
                    if (i_item.last_in)
                        close_clip();
                end
            end
        end
        o_fail_count <= n_fail;
        o_words_due  <= scaled_words_due.size();
    end

endmodule

@@ sim/tb_audio_peak_normalizer_top.sv @@
`timescale 1ns / 100ps
// tb_audio_peak_normalizer_top: drives load/drain words and config writes
// into audio_peak_normalizer_top; apn_gain_checker judges the results. Uses apn_pkg.
module tb_audio_peak_normalizer_top;
    import apn_pkg::*;

    // command word kinds
    localparam logic KIND_LOAD  = 1'b0;
    localparam logic KIND_DRAIN = 1'b1;

    localparam int RANDOM_WORDS = 400;
    localparam int SETTLE_CYCLES = 16;   // drain pipe is 3 deep, rounded up

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   start = 1'b0;
    logic                   busy;
    t_in_word               i_item = '0;
    logic                   o_strobe;
    t_out_word              o_result;
    logic                   i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]   i_cfg_idx = '0;
    logic [SAMPLE_BITS-1:0] i_cfg_data = '0;

    int fail_count;
    int words_due;
    bit no_gaps = 1'b0;     // set for stretches of back-to-back words
    int words_sent;

    always #2 i_clk = ~i_clk;

    audio_peak_normalizer_top dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_item     (i_item),
        .o_strobe   (o_strobe),
        .o_result   (o_result),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    apn_gain_checker chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_busy       (busy),
        .i_item       (i_item),
        .i_strobe     (o_strobe),
        .i_result     (o_result),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .o_fail_count (fail_count),
        .o_words_due  (words_due)
    );

    // Hard stop. Worst case is roughly 4600 words, each with a random gap,
    // a divide and a drain: about 1 ms. Allow 4x that.
    initial begin
        #4_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    // Present one word at the falling edge, hold it until an edge sees
    // start high with busy low, return at the next falling edge. Start is
    // only dropped when a gap is drawn, so back-to-back words keep it high.
    task automatic send_word(input logic kind, input logic [SAMPLE_BITS-1:0] smp,
                             input logic last);
        t_in_word w;
        int       gap;
        w.kind      = kind;
        w.sample_in = smp;
        w.last_in   = last;
        gap = no_gaps ? 0 : $urandom_range(0, 7);
        if (gap != 0) begin
            start <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        start  <= 1'b1;
        i_item <= w;
        do @(posedge i_clk); while (busy);
        @(negedge i_clk);
    endtask

    // Drain word: sample and last fields are don't-care, so fill them randomly.
    task automatic send_drain();
        send_word(KIND_DRAIN, SAMPLE_BITS'($urandom), 1'($urandom));
    endtask

    // Wait until the block is quiet: nothing owed, not busy, and a settling wait
    // for a drain that produces no word.
    task automatic settle();
        start <= 1'b0;
        while (words_due != 0 || busy) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // Write both registers while idle. Mode data carries random upper bits,
    // the block keeps only the low two.
    task automatic set_config(input t_mode m, input logic [SAMPLE_BITS-1:0] tgt);
        settle();
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_MODE;
        i_cfg_data <= {(SAMPLE_BITS-2)'($urandom), m};
        @(negedge i_clk);
        i_cfg_idx  <= CFG_TARGET;
        i_cfg_data <= tgt;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    // Random config, with the target extremes picked often.
    task automatic pick_config();
        logic [SAMPLE_BITS-1:0] tgt;
        case ($urandom_range(0, 7))
            0:       tgt = '0;
            1:       tgt = '1;
            2:       tgt = TARGET_RST;
            3:       tgt = SAMPLE_BITS'(1);
            default: tgt = SAMPLE_BITS'($urandom);
        endcase
        set_config(t_mode'($urandom_range(0, 3)), tgt);
    endtask

    // Sample with a per-clip loudness: shift sets how far down the peak sits,
    // high shifts land under the silence floor.
    function automatic logic [SAMPLE_BITS-1:0] clip_sample(input int shift);
        logic signed [SAMPLE_BITS-1:0] s;
        case ($urandom_range(0, 11))
            0:       s = SAMPLE_MAX;
            1:       s = SAMPLE_SIGN;
            2:       s = SAMPLE_BITS'(int'($urandom_range(0, 9)) *
                                      ($urandom_range(0, 1) ? 1 : -1));
            default: s = $signed(SAMPLE_BITS'($urandom)) >>> shift;
        endcase
        return s;
    endfunction

    initial begin
        int len;
        int shift;
        int n_drain;

        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // --- directed ---
        // reset config (mode none): full-scale extremes pass straight through,
        // fourth drain runs past the end of the clip
        send_word(KIND_LOAD, SAMPLE_MAX, 1'b0);
        send_word(KIND_LOAD, SAMPLE_SIGN, 1'b0);
        send_word(KIND_LOAD, '0, 1'b1);
        repeat (4) send_drain();

        // always scale, all-ones target (4x gain): full-scale clip saturates both ways
        set_config(MODE_ALWAYS, '1);
        send_word(KIND_LOAD, SAMPLE_MAX, 1'b0);
        send_word(KIND_LOAD, SAMPLE_SIGN, 1'b1);
        repeat (2) send_drain();

        // silent clip, peak just under the floor: unity gain
        send_word(KIND_LOAD, SAMPLE_BITS'(7), 1'b0);
        send_word(KIND_LOAD, SAMPLE_BITS'(-7), 1'b1);
        send_drain();

        // peak right at the floor with full-scale target: gain clamps high
        set_config(MODE_RAISE, TARGET_RST);
        send_word(KIND_LOAD, SAMPLE_BITS'(-8), 1'b0);
        // drain inside an open clip gives nothing
        send_drain();
        send_word(KIND_LOAD, SAMPLE_BITS'(3), 1'b1);
        repeat (2) send_drain();

        // lower only, zero target: loud clip goes to silence
        set_config(MODE_LOWER, '0);
        send_word(KIND_LOAD, SAMPLE_BITS'(-123456), 1'b1);
        send_drain();

        // --- store overflow: fill past the depth, extra loads are dropped ---
        set_config(MODE_ALWAYS, TARGET_RST);
        no_gaps = 1'b1;
        for (int k = 0; k < STORE_DEPTH + 3; k++)
            send_word(KIND_LOAD, SAMPLE_BITS'($urandom) >>> 4, k == STORE_DEPTH + 2);
        no_gaps = 1'b0;
        repeat (8) send_drain();

        // --- random clips ---
        // Mostly well-formed: loads ending in last, then drains. Noise: drains
        // inside open clips, drains past the end, clips left partly drained.
        words_sent = 0;
        while (words_sent < RANDOM_WORDS) begin
            if ($urandom_range(0, 3) == 0)
                pick_config();
            no_gaps = ($urandom_range(0, 4) == 0);
            len   = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40)
                                                : $urandom_range(1, 12);
            shift = $urandom_range(0, 23);
            for (int k = 0; k < len; k++) begin
                if (k > 0 && $urandom_range(0, 9) == 0)
                    send_drain();
                send_word(KIND_LOAD, clip_sample(shift), k == len - 1);
                words_sent++;
            end
            n_drain = ($urandom_range(0, 5) == 0) ? $urandom_range(0, len)
                                                  : len + $urandom_range(0, 2);
            repeat (n_drain) begin
                send_drain();
                words_sent++;
            end
        end

        settle();
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

@@ audio_peak_normalizer_top.f @@
sv/apn_pkg.sv
sv/apn_div.sv
sv/audio_peak_normalizer_top.sv
sim/apn_gain_checker.sv
sim/tb_audio_peak_normalizer_top.sv
